[hw/rtl/stb_pkg.sv]
// shared types and constants for the software timer bank
package stb_pkg;

   // command codes carried by a request word
   typedef enum logic [2:0] {
      KIND_TICK   = 3'd0,
      KIND_SET    = 3'd1,
      KIND_START  = 3'd2,
      KIND_STOP   = 3'd3,
      KIND_RELOAD = 3'd4,
      KIND_QUERY  = 3'd5
   } kind_type;

   // result kind codes
   localparam logic RES_EXPIRY = 1'b0;
   localparam logic RES_QUERY  = 1'b1;

   // field widths
   localparam int IDX_FIELD_W = 6;
   localparam int CNT_W       = 16;
   localparam int SUM_W       = 17;

   // set value weights and counter ceiling
   localparam logic [SUM_W-1:0] MIN_WEIGHT = 17'd600;
   localparam logic [SUM_W-1:0] SEC_WEIGHT = 17'd10;
   localparam logic [CNT_W-1:0] CNT_MAX    = 16'hFFFF;

   // classified command passed from front to back
   typedef struct packed {
      kind_type               kind;
      logic [IDX_FIELD_W-1:0] index;
      logic                   in_range;
      logic [CNT_W-1:0]       value;
   } cmd_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TICK,
      ST_TICK_END
   } back_state_type;

endpackage

[hw/rtl/stb_ram.sv]
// generic single write port, single read port ram with registered read
module stb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/stb_queue.sv]
// two-entry command queue between front and back
module stb_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  stb_pkg::cmd_type push_word,
   output logic            full,
   input  logic            pop,
   output stb_pkg::cmd_type pop_word,
   output logic            empty
);
   import stb_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_word = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue pushed while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue popped while empty");
`endif

endmodule

[hw/rtl/stb_front.sv]
// request front end: classifies commands and computes set values
module stb_front #(
   parameter int NUM_TIMERS = 16
) (
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [2:0]      req_kind,
   input  logic [5:0]      req_timer_index,
   input  logic [6:0]      req_minutes,
   input  logic [5:0]      req_seconds,
   input  logic [3:0]      req_tenths,
   output logic            push,
   output stb_pkg::cmd_type push_word,
   input  logic            full
);
   import stb_pkg::*;

   logic             in_range;
   logic             keep;
   logic [SUM_W-1:0] sum;

   assign req_stall = full;

   // range check against the bank size
   assign in_range = ({1'b0, req_timer_index} < 7'(NUM_TIMERS));

   // drop unknown kinds and out of range writes
   always_comb begin
      case (req_kind)
         KIND_TICK:   keep = 1'b1;
         KIND_QUERY:  keep = 1'b1;
         KIND_SET:    keep = in_range;
         KIND_START:  keep = in_range;
         KIND_STOP:   keep = in_range;
         KIND_RELOAD: keep = in_range;
         default:     keep = 1'b0;
      endcase
   end

   // set value in tenths, saturated
   always_comb begin
      sum = SUM_W'(req_minutes) * MIN_WEIGHT + SUM_W'(req_seconds) * SEC_WEIGHT
            + SUM_W'(req_tenths);
   end

   always_comb begin
      push_word.kind     = kind_type'(req_kind);
      push_word.index    = req_timer_index;
      push_word.in_range = in_range;
      push_word.value    = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];
   end

   assign push = req_valid && !full && keep;

endmodule

[hw/rtl/stb_back.sv]
// back end sequencer: executes commands against the timer table
module stb_back #(
   parameter int NUM_TIMERS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            empty,
   input  stb_pkg::cmd_type pop_word,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic            rsp_result_kind,
   output logic [5:0]      rsp_result_index,
   output logic [15:0]     rsp_count_value,
   output logic            rsp_last
);
   import stb_pkg::*;

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int EW = 2 * CNT_W;

   back_state_type         state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [IW-1:0]          cur_ff, cur_in;
   logic [NUM_TIMERS-1:0]  en_ff, en_in;
   logic [NUM_TIMERS-1:0]  vld_ff, vld_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [IDX_FIELD_W-1:0] pend_index_ff, pend_index_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [IDX_FIELD_W-1:0] rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   ram_we, ram_re;
   logic [IW-1:0]          ram_waddr, ram_raddr;
   logic [EW-1:0]          ram_wdata, ram_rdata;

   logic [IW-1:0]          sel_idx;
   logic [IW-1:0]          q_idx;
   logic [CNT_W-1:0]       entry_cnt, entry_reload, dec_cnt;
   logic                   rsp_free, fire, expire, hold;

   // entry of {reload value, counter}
   stb_ram #(.WIDTH(EW), .DEPTH(NUM_TIMERS)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // read data, never-written entries read as zero
   always_comb begin
      sel_idx      = (state_ff == ST_EXEC) ? cmd_ff.index[IW-1:0] : cur_ff;
      q_idx        = pop_word.index[IW-1:0];
      entry_cnt    = vld_ff[sel_idx] ? ram_rdata[CNT_W-1:0] : '0;
      entry_reload = vld_ff[sel_idx] ? ram_rdata[EW-1:CNT_W] : '0;
      dec_cnt      = entry_cnt - 1'b1;
      fire         = en_ff[cur_ff] && (entry_cnt != '0);
      expire       = fire && (dec_cnt == '0);
      rsp_free     = !rsp_valid_ff || !rsp_stall;
      hold         = expire && pend_valid_ff && !rsp_free;
   end

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cur_in        = cur_ff;
      en_in         = en_ff;
      vld_in        = vld_ff;
      pend_valid_in = pend_valid_ff;
      pend_index_in = pend_index_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      pop           = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = sel_idx;
      ram_wdata     = {entry_reload, entry_reload};
      ram_re        = 1'b0;
      ram_raddr     = q_idx;

      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               cmd_in = pop_word;
               case (pop_word.kind)
                  KIND_TICK: begin
                     ram_re    = 1'b1;
                     ram_raddr = '0;
                     cur_in    = '0;
                     state_in  = ST_TICK;
                  end
                  KIND_SET: begin
                     ram_we        = 1'b1;
                     ram_waddr     = q_idx;
                     ram_wdata     = {pop_word.value, pop_word.value};
                     vld_in[q_idx] = 1'b1;
                  end
                  KIND_START: en_in[q_idx] = 1'b1;
                  KIND_STOP:  en_in[q_idx] = 1'b0;
                  KIND_RELOAD, KIND_QUERY: begin
                     ram_re   = 1'b1;
                     state_in = ST_EXEC;
                  end
                  default: ;
               endcase
            end
         end
         ST_EXEC: begin
            if (cmd_ff.kind == KIND_QUERY) begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = RES_QUERY;
                  rsp_index_in = cmd_ff.index;
                  rsp_count_in = cmd_ff.in_range ? entry_cnt : '0;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               ram_we          = 1'b1;
               vld_in[sel_idx] = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (!hold) begin
               if (fire) begin
                  ram_we         = 1'b1;
                  ram_wdata      = {entry_reload, dec_cnt};
                  vld_in[cur_ff] = 1'b1;
               end
               if (expire) begin
                  en_in[cur_ff] = 1'b0;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = RES_EXPIRY;
                     rsp_index_in = pend_index_ff;
                     rsp_count_in = '0;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_index_in = IDX_FIELD_W'(cur_ff);
               end
               if (cur_ff == IW'(NUM_TIMERS - 1)) begin
                  state_in = ST_TICK_END;
               end else begin
                  cur_in    = cur_ff + 1'b1;
                  ram_re    = 1'b1;
                  ram_raddr = cur_ff + 1'b1;
               end
            end
         end
         ST_TICK_END: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = RES_EXPIRY;
               rsp_index_in  = pend_index_ff;
               rsp_count_in  = '0;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         en_ff         <= '0;
         vld_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         en_ff         <= en_in;
         vld_ff        <= vld_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cur_ff        <= cur_in;
      pend_index_ff <= pend_index_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_count_value  = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTH
   a_pend_in_tick: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == ST_TICK || state_ff == ST_TICK_END))
      else $error("pending expiry outside a tick sweep");
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("table read and write at the same entry");
   a_expiry_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == RES_EXPIRY) |-> (rsp_count_ff == '0))
      else $error("expiry word with nonzero count");
   a_query_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == RES_QUERY) |-> rsp_last_ff)
      else $error("query answer not marked last");
`endif

endmodule

[hw/rtl/software_timer_bank_core.sv]
// software timer bank: top level joining front end, command queue and back end
//
// Bank of NUM_TIMERS one-shot down counters driven by one command word per
// request: tick, set, start, stop, reload or query. Both channels use
// valid/stall; a word moves on a clock edge with valid high and stall low.
// The front end classifies each request, drops unknown kinds and out of range
// writes, and computes the set value in tenths (saturated at 65535). A
// two-entry queue feeds the back end, which owns the timer table in a ram.
// Set, start and stop finish in the idle state; reload and query go on to an
// execute state after one table read. A tick sweeps the table one timer per
// cycle while the sweep is not held, and emits one expiry word per timer
// that reaches zero, the final one with last set. A query always gives one
// word with last set; set, start, stop and reload give none.
// Results sit in an output register; a stalled result holds the sweep only
// when another expiry is found while one is already pending. Requests are
// taken until the queue is full. Reset clears all counters, reload values and
// enables at once.
module software_timer_bank_core #(
   parameter int NUM_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [5:0]  req_timer_index,
   input  logic [6:0]  req_minutes,
   input  logic [5:0]  req_seconds,
   input  logic [3:0]  req_tenths,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [5:0]  rsp_result_index,
   output logic [15:0] rsp_count_value,
   output logic        rsp_last
);
   import stb_pkg::*;

   cmd_type push_word, pop_word;
   logic    push, pop, full, empty;

   // classify and precompute
   stb_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_timer_index (req_timer_index),
      .req_minutes     (req_minutes),
      .req_seconds     (req_seconds),
      .req_tenths      (req_tenths),
      .push            (push),
      .push_word       (push_word),
      .full            (full)
   );

   // decoupling queue
   stb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (full),
      .pop       (pop),
      .pop_word  (pop_word),
      .empty     (empty)
   );

   // command execution
   stb_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (empty),
      .pop_word         (pop_word),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_result_index (rsp_result_index),
      .rsp_count_value  (rsp_count_value),
      .rsp_last         (rsp_last)
   );

endmodule
